/* hdl/clns_pkg.sv */
// Shared types, codes and step tables for the character LCD nibble sequencer.
package clns_pkg;

  localparam int OP_W    = 3;
  localparam int VAL_W   = 8;
  localparam int NIB_W   = 4;
  localparam int HOLD_W  = 14;
  localparam int IDX_W   = 5;

  // request codes
  localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_CMD   = 3'd1;
  localparam logic [OP_W-1:0] OP_CHAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
  localparam logic [OP_W-1:0] OP_ADDR  = 3'd4;

  // bytes of the fixed sequences
  localparam logic [VAL_W-1:0] FUNC_SET_4BIT = 8'h28;
  localparam logic [VAL_W-1:0] DISP_OFF      = 8'h08;
  localparam logic [VAL_W-1:0] DISP_ON_BLINK = 8'h0F;
  localparam logic [VAL_W-1:0] ENTRY_MODE    = 8'h06;
  localparam logic [VAL_W-1:0] CLEAR_DISP    = 8'h01;
  localparam logic [VAL_W-1:0] DISP_ON       = 8'h0C;
  localparam logic [VAL_W-1:0] SET_DDRAM     = 8'h80;
  localparam logic [NIB_W-1:0] WAKE_NIB      = 4'h3;
  localparam logic [NIB_W-1:0] MODE4_NIB     = 4'h2;

  // hold times in cycles
  localparam logic [HOLD_W-1:0] HOLD_POWER_UP = 14'd15000;
  localparam logic [HOLD_W-1:0] HOLD_WAKE     = 14'd5000;
  localparam logic [HOLD_W-1:0] HOLD_SHORT    = 14'd100;
  localparam logic [HOLD_W-1:0] PULSE_HOLD    = 14'd10;
  localparam logic [HOLD_W-1:0] BYTE_SETTLE   = 14'd40;
  localparam logic [HOLD_W-1:0] CLEAR_SETTLE  = 14'd2040;

  // last step index of each run, and the first byte step of init
  localparam logic [IDX_W-1:0] LAST_INIT  = 5'd24;
  localparam logic [IDX_W-1:0] LAST_CLEAR = 5'd7;
  localparam logic [IDX_W-1:0] LAST_BYTE  = 5'd3;
  localparam logic [IDX_W-1:0] INIT_BYTES = 5'd9;

  typedef struct packed {
    logic [NIB_W-1:0]  nibble;
    logic              sel;
    logic              en;
    logic [HOLD_W-1:0] hold;
  } step_t;

  typedef struct packed {
    logic             load;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  function automatic logic op_known(logic [OP_W-1:0] op);
    return op <= OP_ADDR;
  endfunction

  function automatic logic [IDX_W-1:0] last_index(logic [OP_W-1:0] op);
    logic [IDX_W-1:0] n;
    case (op)
      OP_INIT:  n = LAST_INIT;
      OP_CLEAR: n = LAST_CLEAR;
      default:  n = LAST_BYTE;
    endcase
    return n;
  endfunction

  // one of the four steps of a byte: high pulse, high low, low pulse, low settle
  function automatic step_t byte_step(logic [VAL_W-1:0] b, logic sel, logic [1:0] sub,
                                      logic [HOLD_W-1:0] settle);
    step_t s;
    s.nibble = sub[1] ? b[3:0] : b[7:4];
    s.sel    = sel;
    s.en     = ~sub[0];
    s.hold   = sub[0] ? (sub[1] ? settle : '0) : PULSE_HOLD;
    return s;
  endfunction

  function automatic step_t init_step(logic [NIB_W-1:0] held, logic [IDX_W-1:0] k);
    step_t            s;
    logic [IDX_W-1:0] j;
    logic [VAL_W-1:0] b;
    j = k - INIT_BYTES;
    case (j[3:2])
      2'd0:    b = FUNC_SET_4BIT;
      2'd1:    b = DISP_OFF;
      2'd2:    b = DISP_ON_BLINK;
      default: b = ENTRY_MODE;
    endcase
    if (k == '0) begin
      s.nibble = held;
      s.sel    = 1'b0;
      s.en     = 1'b0;
      s.hold   = HOLD_POWER_UP;
    end else if (k < INIT_BYTES) begin
      s.nibble = (k >= 5'd7) ? MODE4_NIB : WAKE_NIB;
      s.sel    = 1'b0;
      s.en     = k[0];
      if (k[0])
        s.hold = PULSE_HOLD;
      else if (k == 5'd2 || k == 5'd6)
        s.hold = HOLD_WAKE;
      else
        s.hold = HOLD_SHORT;
    end else begin
      s = byte_step(b, 1'b0, j[1:0], BYTE_SETTLE);
    end
    return s;
  endfunction

  function automatic step_t step_fields(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                                        logic [NIB_W-1:0] held, logic [IDX_W-1:0] k);
    step_t s;
    case (op)
      OP_INIT:  s = init_step(held, k);
      OP_CMD:   s = byte_step(val, 1'b0, k[1:0], BYTE_SETTLE);
      OP_CHAR:  s = byte_step(val, 1'b1, k[1:0], BYTE_SETTLE);
      OP_CLEAR: s = byte_step(k[2] ? DISP_ON : CLEAR_DISP, 1'b0, k[1:0], CLEAR_SETTLE);
      OP_ADDR:  s = byte_step(SET_DDRAM | {1'b0, val[6:0]}, 1'b0, k[1:0], BYTE_SETTLE);
      default:  s = '0;
    endcase
    return s;
  endfunction

endpackage

/* hdl/clns_ctrl.sv */
// Controller: request handshake, step counter and output valid.
module clns_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [clns_pkg::OP_W-1:0]     in_operation,
  output logic                          out_valid,
  input  logic                          out_ready,
  output clns_pkg::ctrl_cmd_t           cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                          state_r, state_nxt;
  logic [clns_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [clns_pkg::IDX_W-1:0]    last_idx_r, last_idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          accept;
  logic                          emit;
  logic                          at_last;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign emit     = (state_r == ST_RUN) & (~out_valid_r | out_ready);
  assign at_last  = (idx_r == last_idx_r);

  assign cmd.load = accept;
  assign cmd.emit = emit;
  assign cmd.last = at_last;
  assign cmd.idx  = idx_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    out_valid_nxt = out_valid_r;
    if (out_ready)
      out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && clns_pkg::op_known(in_operation)) begin
          state_nxt    = ST_RUN;
          idx_nxt      = '0;
          last_idx_nxt = clns_pkg::last_index(in_operation);
        end
      end
      ST_RUN: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          idx_nxt       = idx_r + 1'b1;
          if (at_last)
            state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      last_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      last_idx_r  <= last_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/clns_dp.sv */
// Datapath: request registers, held nibble and the registered output word.
module clns_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clns_pkg::ctrl_cmd_t           cmd,
  input  logic [clns_pkg::OP_W-1:0]     in_operation,
  input  logic [clns_pkg::VAL_W-1:0]    in_value,
  output logic [clns_pkg::NIB_W-1:0]    out_data_nibble,
  output logic                          out_reg_select,
  output logic                          out_enable,
  output logic [clns_pkg::HOLD_W-1:0]   out_hold_cycles,
  output logic                          out_last
);

  logic [clns_pkg::OP_W-1:0]   op_r;
  logic [clns_pkg::VAL_W-1:0]  val_r;
  logic [clns_pkg::NIB_W-1:0]  held_r;
  clns_pkg::step_t             step_r, step_nxt;
  logic                        last_r;

  assign step_nxt = clns_pkg::step_fields(op_r, val_r, held_r, cmd.idx);

  // request capture and output word; no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      val_r <= in_value;
    end
    if (cmd.emit) begin
      step_r <= step_nxt;
      last_r <= cmd.last;
    end
  end

  // data lines as last driven; feeds the first init step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.emit) begin
      held_r <= step_nxt.nibble;
    end
  end

  assign out_data_nibble = step_r.nibble;
  assign out_reg_select  = step_r.sel;
  assign out_enable      = step_r.en;
  assign out_hold_cycles = step_r.hold;
  assign out_last        = last_r;

endmodule

/* hdl/char_lcd_nibble_sequencer.sv */
// Top level of the character LCD nibble sequencer (4-bit bus step generator).
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------------
//  in_     | in_valid / in_ready  | operation[2:0], value[7:0]
//  out_    | out_valid / out_ready| data_nibble[3:0], reg_select, enable,
//          |                      | hold_cycles[13:0], last
//
//  One request at a time: in_ready is high only while no run is in progress.
//  A run is 4 steps (command, character, set address), 8 (clear) or 25 (init);
//  the step counter in the controller issues one step a cycle into the output
//  register while out_ready stays high.
//  An unknown operation is accepted and gives no words.
//  A stall on out_ready holds the output word and pauses the step counter.
//  Synchronous reset clears the controller and zeroes the held nibble.
module char_lcd_nibble_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [clns_pkg::OP_W-1:0]     in_operation,
  input  logic [clns_pkg::VAL_W-1:0]    in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [clns_pkg::NIB_W-1:0]    out_data_nibble,
  output logic                          out_reg_select,
  output logic                          out_enable,
  output logic [clns_pkg::HOLD_W-1:0]   out_hold_cycles,
  output logic                          out_last
);

  // controller to datapath: capture request, emit step idx, last flag
  clns_pkg::ctrl_cmd_t cmd;

  clns_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  // step tables live in the package; datapath registers the chosen word
  clns_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_data_nibble (out_data_nibble),
    .out_reg_select  (out_reg_select),
    .out_enable      (out_enable),
    .out_hold_cycles (out_hold_cycles),
    .out_last        (out_last)
  );

endmodule
